[rtl/core/pvt_pkg.sv]
// shared constants and types for the perspective vertex transform
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package pvt_pkg;
    localparam int COORD_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF   = 16;

    typedef enum logic {
        OP_LOAD  = 1'b0,
        OP_XFORM = 1'b1
    } t_op;
endpackage
`default_nettype wire

[rtl/core/pvt_div_lane.sv]
// pipelined unsigned restoring divider, one quotient bit per stage
// flags quotients that do not fit in QW bits; no package dependency
`timescale 1ns / 1ps
`default_nettype none
module pvt_div_lane #(
    parameter int NW = 82,
    parameter int DW = 66,
    parameter int QW = 32
) (
    input  wire logic          i_clk,
    input  wire logic [NW-1:0] i_num,
    input  wire logic [DW-1:0] i_den,
    output logic      [QW-1:0] o_quot,
    output logic               o_ovf
);
    localparam int XW = ((NW > DW + QW) ? NW : DW + QW) + 1;

    logic [XW-1:0] r_rem  [QW+1];
    logic [XW-1:0] r_den  [QW+1];
    logic [QW-1:0] r_quot [QW+1];
    logic          r_ovf  [QW+1];

    // first stage: any quotient at or above 2^QW is an overflow
    always_ff @(posedge i_clk) begin
        r_rem[0]  <= XW'(i_num);
        r_den[0]  <= XW'(i_den);
        r_quot[0] <= '0;
        r_ovf[0]  <= (XW'(i_num) >= (XW'(i_den) << QW));
    end

    for (genvar j = 1; j <= QW; j++) begin : g_step
        localparam int K = QW - j;
        logic [XW-1:0] w_trial;
        logic          w_take;
        assign w_trial = r_den[j-1] << K;
        assign w_take  = (r_rem[j-1] >= w_trial);
        always_ff @(posedge i_clk) begin
            r_rem[j]  <= w_take ? (r_rem[j-1] - w_trial) : r_rem[j-1];
            r_den[j]  <= r_den[j-1];
            r_quot[j] <= r_quot[j-1] | (QW'(w_take) << K);
            r_ovf[j]  <= r_ovf[j-1];
        end
    end

    assign o_quot = r_quot[QW];
    assign o_ovf  = r_ovf[QW];
endmodule
`default_nettype wire

[rtl/core/perspective_vertex_transform.sv]
// a transform passes through stages 0 to 2, the divider lanes and the output register to o_valid
// throughput: one transaction per cycle; busy is never raised and loads give no result
// the depth is set by the divider, one quotient bit per stage in each of three lanes
// reset (synchronous, active low) clears the matrix to zero and all valid bits
// the receiver cannot stall; each result is shown for exactly one cycle
`timescale 1ns / 1ps
`default_nettype none
module perspective_vertex_transform #(
    parameter int COORD_WIDTH = pvt_pkg::COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = pvt_pkg::FRAC_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic                          i_operation,
    input  wire logic [3:0]                    i_entry_index,
    input  wire logic signed [COORD_WIDTH-1:0] i_coefficient,
    input  wire logic signed [COORD_WIDTH-1:0] i_vertex_x,
    input  wire logic signed [COORD_WIDTH-1:0] i_vertex_y,
    input  wire logic signed [COORD_WIDTH-1:0] i_vertex_z,
    output logic                               o_valid,
    output logic signed [COORD_WIDTH-1:0]      o_proj_x,
    output logic signed [COORD_WIDTH-1:0]      o_proj_y,
    output logic signed [COORD_WIDTH-1:0]      o_proj_z,
    output logic                               o_w_was_zero,
    output logic                               o_saturated
);
    import pvt_pkg::*;

    localparam int CW  = COORD_WIDTH;
    localparam int PW  = 2 * CW;
    localparam int AW  = ((PW > CW + FRAC_BITS) ? PW : CW + FRAC_BITS) + 2;
    localparam int NW  = AW + FRAC_BITS;
    localparam int DL  = CW + 1;
    localparam logic [CW-1:0] MAXV = {1'b0, {(CW-1){1'b1}}};
    localparam logic [CW-1:0] MINV = {1'b1, {(CW-1){1'b0}}};

    logic w_accept;
    assign busy     = 1'b0;
    assign w_accept = start && !busy;

    // matrix store
    logic signed [CW-1:0] r_mat [16];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int e = 0; e < 16; e++) r_mat[e] <= '0;
        end else if (w_accept && i_operation == OP_LOAD) begin
            r_mat[i_entry_index] <= i_coefficient;
        end
    end

    // stage 0: products, taken against the matrix as it stands at accept
    logic signed [CW-1:0] w_vert [3];
    assign w_vert[0] = i_vertex_x;
    assign w_vert[1] = i_vertex_y;
    assign w_vert[2] = i_vertex_z;

    logic                 r_v0;
    logic signed [PW-1:0] r_prod  [3][4];
    logic signed [CW-1:0] r_trans [4];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v0 <= 1'b0;
        else          r_v0 <= w_accept && i_operation == OP_XFORM;
        for (int r = 0; r < 3; r++)
            for (int c = 0; c < 4; c++)
                r_prod[r][c] <= PW'(w_vert[r]) * PW'(r_mat[r*4+c]);
        for (int c = 0; c < 4; c++) r_trans[c] <= r_mat[12+c];
    end

    // stage 1: column sums
    logic                 r_v1;
    logic signed [AW-1:0] r_acc [4];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v1 <= 1'b0;
        else          r_v1 <= r_v0;
        for (int c = 0; c < 4; c++)
            r_acc[c] <= (AW'(r_trans[c]) <<< FRAC_BITS) + AW'(r_prod[0][c])
                      + AW'(r_prod[1][c]) + AW'(r_prod[2][c]);
    end

    // stage 2: signs, magnitudes and the rounded path for zero w
    logic                 r_v2;
    logic                 r_wz2;
    logic [NW-1:0]        r_num  [3];
    logic [AW-1:0]        r_den;
    logic                 r_neg2 [3];
    logic [CW-1:0]        r_zval2[3];
    logic                 r_zsat2[3];
    logic signed [AW:0]   w_rnd  [3];
    logic [AW-CW+1:0]     w_rhi  [3];
    logic                 w_fit  [3];
    logic [AW-1:0]        w_mag  [3];

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            w_rnd[c] = ((AW+1)'(r_acc[c]) + (AW+1)'(signed'(1) <<< (FRAC_BITS-1)))
                       >>> FRAC_BITS;
            w_rhi[c] = w_rnd[c][AW:CW-1];
            w_fit[c] = (&w_rhi[c]) || !(|w_rhi[c]);
            w_mag[c] = r_acc[c][AW-1] ? AW'(-r_acc[c]) : AW'(r_acc[c]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v2 <= 1'b0;
        else          r_v2 <= r_v1;
        r_wz2 <= (r_acc[3] == '0);
        r_den <= r_acc[3][AW-1] ? AW'(-r_acc[3]) : AW'(r_acc[3]);
        for (int c = 0; c < 3; c++) begin
            r_num[c]   <= NW'(w_mag[c]) << FRAC_BITS;
            r_neg2[c]  <= r_acc[c][AW-1] ^ r_acc[3][AW-1];
            r_zval2[c] <= w_fit[c] ? w_rnd[c][CW-1:0] : (w_rnd[c][AW] ? MINV : MAXV);
            r_zsat2[c] <= !w_fit[c];
        end
    end

    // divider lanes
    logic [CW-1:0] w_quot [3];
    logic          w_ovf  [3];
    for (genvar c = 0; c < 3; c++) begin : g_lane
        pvt_div_lane #(
            .NW (NW),
            .DW (AW),
            .QW (CW)
        ) u_div (
            .i_clk  (i_clk),
            .i_num  (r_num[c]),
            .i_den  (r_den),
            .o_quot (w_quot[c]),
            .o_ovf  (w_ovf[c])
        );
    end

    // side information travels alongside the divider
    logic          r_dv   [DL];
    logic          r_dwz  [DL];
    logic          r_dneg [DL][3];
    logic [CW-1:0] r_dzval[DL][3];
    logic          r_dzsat[DL][3];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < DL; s++) r_dv[s] <= 1'b0;
        end else begin
            r_dv[0] <= r_v2;
            for (int s = 1; s < DL; s++) r_dv[s] <= r_dv[s-1];
        end
        r_dwz[0] <= r_wz2;
        for (int c = 0; c < 3; c++) begin
            r_dneg[0][c]  <= r_neg2[c];
            r_dzval[0][c] <= r_zval2[c];
            r_dzsat[0][c] <= r_zsat2[c];
        end
        for (int s = 1; s < DL; s++) begin
            r_dwz[s] <= r_dwz[s-1];
            for (int c = 0; c < 3; c++) begin
                r_dneg[s][c]  <= r_dneg[s-1][c];
                r_dzval[s][c] <= r_dzval[s-1][c];
                r_dzsat[s][c] <= r_dzsat[s-1][c];
            end
        end
    end

    // final sign and clamp
    logic [CW-1:0] n_val [3];
    logic          n_sat [3];
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            if (r_dwz[DL-1]) begin
                n_val[c] = r_dzval[DL-1][c];
                n_sat[c] = r_dzsat[DL-1][c];
            end else if (w_ovf[c]) begin
                n_val[c] = r_dneg[DL-1][c] ? MINV : MAXV;
                n_sat[c] = 1'b1;
            end else if (!r_dneg[DL-1][c]) begin
                n_sat[c] = w_quot[c][CW-1];
                n_val[c] = n_sat[c] ? MAXV : w_quot[c];
            end else begin
                n_sat[c] = (w_quot[c] > MINV);
                n_val[c] = n_sat[c] ? MINV : (CW'(0) - w_quot[c]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid      <= 1'b0;
            o_w_was_zero <= 1'b0;
            o_saturated  <= 1'b0;
        end else begin
            o_valid      <= r_dv[DL-1];
            o_w_was_zero <= r_dv[DL-1] && r_dwz[DL-1];
            o_saturated  <= r_dv[DL-1] && (n_sat[0] || n_sat[1] || n_sat[2]);
        end
        o_proj_x <= n_val[0];
        o_proj_y <= n_val[1];
        o_proj_z <= n_val[2];
    end

    // a load never sends a transaction down the pipeline
    a_load_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_operation == OP_LOAD) |=> !r_v0)
        else $error("load entered the pipeline");

    // a load to entry 0 lands in matrix entry 0
    a_load_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_operation == OP_LOAD && i_entry_index == 4'd0)
        |=> (r_mat[0] == $past(i_coefficient)))
        else $error("matrix entry not written");

    // flags only accompany a result
    a_flags_with_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> (!o_w_was_zero && !o_saturated))
        else $error("flag without result");

    // a transform in stage 2 reaches the output after the divider depth and the output register
    a_valid_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v2 |-> ##(DL+1) o_valid)
        else $error("result lost in pipeline");
endmodule
`default_nettype wire

[bench/perspective_vertex_transform_checker.sv]
// checker for the perspective vertex transform: tracks the matrix, predicts each projection
// depends on pvt_pkg and watches the ports of perspective_vertex_transform
`timescale 1ns / 1ps
`default_nettype none
module perspective_vertex_transform_checker
    import pvt_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic               i_busy,
    input  wire logic               i_operation,
    input  wire logic [3:0]         i_entry_index,
    input  wire logic signed [31:0] i_coefficient,
    input  wire logic signed [31:0] i_vertex_x,
    input  wire logic signed [31:0] i_vertex_y,
    input  wire logic signed [31:0] i_vertex_z,
    input  wire logic               i_valid,
    input  wire logic signed [31:0] i_proj_x,
    input  wire logic signed [31:0] i_proj_y,
    input  wire logic signed [31:0] i_proj_z,
    input  wire logic               i_w_was_zero,
    input  wire logic               i_saturated,
    output int                      o_fail_count,
    output int                      o_pending
);
    typedef struct packed {
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] pz;
        logic               wz;
        logic               sat;
    } t_proj;

    logic signed [31:0] proj_matrix [16];
    t_proj              projections_due [$];

    localparam logic signed [127:0] Q_MAX = 128'sd2147483647;
    localparam logic signed [127:0] Q_MIN = -128'sd2147483648;

    assign o_pending = projections_due.size();

    function automatic logic signed [31:0] clamp_q(input logic signed [127:0] v,
                                                   inout logic sat);
        if (v > Q_MAX) begin
            sat = 1'b1;
            return Q_MAX[31:0];
        end
        if (v < Q_MIN) begin
            sat = 1'b1;
            return Q_MIN[31:0];
        end
        return v[31:0];
    endfunction

    function automatic t_proj project_vertex(input logic signed [31:0] vx,
                                             input logic signed [31:0] vy,
                                             input logic signed [31:0] vz);
        logic signed [127:0] col [4];
        logic signed [127:0] q;
        logic signed [31:0]  res [3];
        logic                sat;
        t_proj               p;
        sat = 1'b0;
        for (int c = 0; c < 4; c++) begin
            col[c] = 128'(proj_matrix[12 + c]) <<< 16;
            col[c] += 128'(vx) * 128'(proj_matrix[c]);
            col[c] += 128'(vy) * 128'(proj_matrix[4 + c]);
            col[c] += 128'(vz) * 128'(proj_matrix[8 + c]);
        end
        for (int c = 0; c < 3; c++) begin
            // zero w: round half up to Q16.16, no divide
            if (col[3] == 0) q = (col[c] + 128'sd32768) >>> 16;
            else q = (col[c] <<< 16) / col[3];
            res[c] = clamp_q(q, sat);
        end
        p.px  = res[0];
        p.py  = res[1];
        p.pz  = res[2];
        p.wz  = (col[3] == 0);
        p.sat = sat;
        return p;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
        o_fail_count++;
    endtask

    always @(posedge i_clk) begin
        t_proj e;
        if (!i_rst_n) begin
            for (int k = 0; k < 16; k++) proj_matrix[k] <= '0;
            projections_due.delete();
            o_fail_count = 0;
        end else begin
            if (i_valid) begin
                if (projections_due.size() == 0) begin
                    report_mismatch("unexpected projection", i_proj_x, 0);
                end else begin
                    e = projections_due.pop_front();
                    if (i_proj_x !== e.px) report_mismatch("proj_x", i_proj_x, e.px);
                    if (i_proj_y !== e.py) report_mismatch("proj_y", i_proj_y, e.py);
                    if (i_proj_z !== e.pz) report_mismatch("proj_z", i_proj_z, e.pz);
                    if (i_w_was_zero !== e.wz)
                        report_mismatch("w_was_zero", 32'(i_w_was_zero), 32'(e.wz));
                    if (i_saturated !== e.sat)
                        report_mismatch("saturated", 32'(i_saturated), 32'(e.sat));
                end
            end
            if (i_start && !i_busy) begin
                if (t_op'(i_operation) == OP_LOAD) proj_matrix[i_entry_index] <= i_coefficient;
                else projections_due.push_back(project_vertex(i_vertex_x, i_vertex_y,
                                                              i_vertex_z));
            end
        end
    end
endmodule
`default_nettype wire

[bench/perspective_vertex_transform_tb.sv]
// top of the perspective vertex transform bench: matrix loads, vertex stimulus, verdict
// depends on pvt_pkg, perspective_vertex_transform and perspective_vertex_transform_checker
`timescale 1ns / 1ps
`default_nettype none
module perspective_vertex_transform_tb;
    import pvt_pkg::*;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic               i_operation = OP_LOAD;
    logic [3:0]         i_entry_index = '0;
    logic signed [31:0] i_coefficient = '0;
    logic signed [31:0] i_vertex_x = '0;
    logic signed [31:0] i_vertex_y = '0;
    logic signed [31:0] i_vertex_z = '0;
    logic               o_valid;
    logic signed [31:0] o_proj_x, o_proj_y, o_proj_z;
    logic               o_w_was_zero, o_saturated;
    int                 fail_count, pending;
    int                 idle_pct;

    localparam logic [31:0] ONE_Q = 32'h0001_0000;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    perspective_vertex_transform u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_operation(i_operation), .i_entry_index(i_entry_index),
        .i_coefficient(i_coefficient), .i_vertex_x(i_vertex_x),
        .i_vertex_y(i_vertex_y), .i_vertex_z(i_vertex_z), .o_valid(o_valid),
        .o_proj_x(o_proj_x), .o_proj_y(o_proj_y), .o_proj_z(o_proj_z),
        .o_w_was_zero(o_w_was_zero), .o_saturated(o_saturated)
    );

    perspective_vertex_transform_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start), .i_busy(busy),
        .i_operation(i_operation), .i_entry_index(i_entry_index),
        .i_coefficient(i_coefficient), .i_vertex_x(i_vertex_x),
        .i_vertex_y(i_vertex_y), .i_vertex_z(i_vertex_z), .i_valid(o_valid),
        .i_proj_x(o_proj_x), .i_proj_y(o_proj_y), .i_proj_z(o_proj_z),
        .i_w_was_zero(o_w_was_zero), .i_saturated(o_saturated),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // skewed values: extremes, small fixed-point numbers or full random
    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return '0;
            3: return ONE_Q;
            4, 5: return 32'($signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000);
            default: return $urandom();
        endcase
    endfunction

    // one transaction; random idle cycles before it, start held between back-to-back items
    task automatic send_item(input t_op op, input logic [3:0] idx, input logic [31:0] coef,
                             input logic [31:0] vx, input logic [31:0] vy,
                             input logic [31:0] vz);
        while ($urandom_range(0, 99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start         <= 1'b1;
        i_operation   <= op;
        i_entry_index <= idx;
        i_coefficient <= coef;
        i_vertex_x    <= vx;
        i_vertex_y    <= vy;
        i_vertex_z    <= vz;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    task automatic load_entry(input logic [3:0] idx, input logic [31:0] coef);
        send_item(OP_LOAD, idx, coef, $urandom(), $urandom(), $urandom());
    endtask

    task automatic xform(input logic [31:0] vx, input logic [31:0] vy, input logic [31:0] vz);
        send_item(OP_XFORM, 4'($urandom()), $urandom(), vx, vy, vz);
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    initial begin
        idle_pct = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // zero matrix gives w of zero
        xform(32'h7fff_ffff, 32'h8000_0000, ONE_Q);
        // identity, then divide by one
        for (int k = 0; k < 4; k++) load_entry(4'(k * 5), ONE_Q);
        xform(32'h0003_8000, 32'hfffe_4000, 32'h7fff_ffff);
        xform(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        // tiny w forces saturation both ways
        load_entry(4'd15, 32'h0000_0001);
        xform(32'h7fff_ffff, 32'h8000_0000, 32'h0000_0001);
        // w zero with a rounding half and overflowing sums
        load_entry(4'd15, '0);
        load_entry(4'd0, 32'h7fff_ffff);
        load_entry(4'd12, 32'h0000_8000);
        xform(32'h0000_0001, '0, '0);
        xform(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
        // negative w with perspective column
        load_entry(4'd11, 32'hffff_0000);
        load_entry(4'd15, 32'h8000_0000);
        xform(32'h0001_0000, 32'hffff_0000, 32'h0002_0000);
        xform(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);
        drain();

        for (int ph = 0; ph < 3; ph++) begin
            idle_pct = (ph == 0) ? 10 : (ph == 1) ? 76 : 0;
            for (int n = 0; n < 500; n++) begin
                if ($urandom_range(0, 3) == 0)
                    load_entry(4'($urandom_range(0, 15)), pick_value());
                else
                    xform(pick_value(), pick_value(), pick_value());
                // occasionally let the pipeline empty out
                if ($urandom_range(0, 199) == 0) drain();
            end
            drain();
        end

        repeat (50) @(posedge i_clk);
        if (fail_count == 0) $display("Test completed successfully");
        else $display("Test completed with failures");
        $finish;
    end

    initial begin
        #2000000;
        $display("Test completed with failures");
        $finish;
    end
endmodule
`default_nettype wire

[perspective_vertex_transform.f]
rtl/core/pvt_pkg.sv
rtl/core/pvt_div_lane.sv
rtl/core/perspective_vertex_transform.sv
bench/perspective_vertex_transform_checker.sv
bench/perspective_vertex_transform_tb.sv
